// File: design/mma_pkg.sv
// ----------------------------------------------------------------------------
// mma_pkg
// Shared types and constants for the matrix multiply-accumulate block.
// ----------------------------------------------------------------------------
package mma_pkg;

   localparam int MaxDim = 32;
   localparam int IdxW   = $clog2(MaxDim);
   localparam int AddrW  = 2 * IdxW;
   localparam int Depth  = MaxDim * MaxDim;
   localparam int DimW   = 3;
   localparam int ValW   = 16;
   localparam int AccW   = 32;

   localparam logic [DimW-1:0] DimLog2Reset = DimW'(5);

   typedef enum logic [1:0] {
      REQ_WRITE_X  = 2'd0,
      REQ_WRITE_Y  = 2'd1,
      REQ_MULTIPLY = 2'd2,
      REQ_READ_Z   = 2'd3
   } req_code_type;

   typedef struct packed {
      req_code_type            req_type;
      logic [IdxW-1:0]         row;
      logic [IdxW-1:0]         col;
      logic signed [ValW-1:0]  value;
   } req_payload_type;

   typedef struct packed {
      logic signed [AccW-1:0]  read_value;
      logic                    is_read;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_LOAD,
      ST_SWEEP,
      ST_DRAIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic clear_en;
      logic write_x;
      logic write_y;
      logic mac_start;
      logic load_a;
      logic issue;
      logic row_next;
      logic rsp_load_zero;
      logic rsp_load_read;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic j_last;
      logic row_last;
      logic pipe_busy;
   } status_type;

endpackage

// File: design/mma_ctrl.sv
// ----------------------------------------------------------------------------
// mma_ctrl
// Sequencer: Z clearing pass, item handshake, multiply loop control and
// result valid.
// ----------------------------------------------------------------------------
module mma_ctrl
   import mma_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_code_type req_code,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  status_type   status,
   output cmd_type      cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (req_code)
                  REQ_MULTIPLY: state_in = ST_LOAD;
                  REQ_READ_Z:   state_in = ST_READ;
                  default:      state_in = ST_IDLE;
               endcase
            end
         end
         ST_READ:  state_in = ST_IDLE;
         ST_LOAD:  state_in = ST_SWEEP;
         ST_SWEEP: begin
            if (status.j_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) state_in = status.row_last ? ST_DONE : ST_LOAD;
         end
         ST_DONE:  state_in = ST_IDLE;
         default:  state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_CLEAR: cmd.clear_en = 1'b1;
         ST_IDLE: begin
            if (accept) begin
               unique case (req_code)
                  REQ_WRITE_X: begin
                     cmd.write_x       = 1'b1;
                     cmd.rsp_load_zero = 1'b1;
                  end
                  REQ_WRITE_Y: begin
                     cmd.write_y       = 1'b1;
                     cmd.rsp_load_zero = 1'b1;
                  end
                  REQ_MULTIPLY: cmd.mac_start = 1'b1;
                  default: ;
               endcase
            end
         end
         ST_READ:  cmd.rsp_load_read = 1'b1;
         ST_LOAD:  cmd.load_a = 1'b1;
         ST_SWEEP: cmd.issue = 1'b1;
         ST_DRAIN: cmd.row_next = !status.pipe_busy && !status.row_last;
         ST_DONE:  cmd.rsp_load_zero = 1'b1;
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load_zero || cmd.rsp_load_read) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: design/mma_dpath.sv
// ----------------------------------------------------------------------------
// mma_dpath
// Element stores, loop counters, multiply-add pipeline and result register.
// ----------------------------------------------------------------------------
module mma_dpath
   import mma_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_wr_en,
   input  logic [DimW-1:0] csr_wr_data,
   input  req_payload_type req_payload,
   input  cmd_type         cmd,
   output status_type      status,
   output rsp_payload_type rsp_payload
);

   logic [DimW-1:0]        dim_log2_ff;
   logic [IdxW:0]          dim_size;
   logic [IdxW-1:0]        last_idx;

   logic [IdxW-1:0]        i_ff, i_in, k_ff, k_in, j_ff, j_in;
   logic [AddrW-1:0]       clr_cnt_ff, clr_cnt_in;

   logic                   p1_vld_ff, p2_vld_ff;
   logic [AddrW-1:0]       p1_addr_ff, p2_addr_ff;

   logic signed [ValW-1:0] x_mem [Depth];
   logic signed [ValW-1:0] y_mem [Depth];
   logic [AccW-1:0]        z_mem [Depth];

   logic signed [ValW-1:0] x_rd_ff, y_rd_ff;
   logic [AccW-1:0]        z_rd_ff, z_hold_ff;
   logic signed [AccW-1:0] prod_in, prod_ff;

   logic [AddrW-1:0]       req_addr, z_raddr, z_waddr;
   logic                   z_we;
   logic [AccW-1:0]        z_wdata;

   rsp_payload_type        rsp_ff, rsp_in;

   always_ff @(posedge clock) begin
      if (reset) dim_log2_ff <= DimLog2Reset;
      else if (csr_wr_en) dim_log2_ff <= csr_wr_data;
   end

   assign dim_size = (IdxW+1)'(1) << dim_log2_ff;
   assign last_idx = (dim_log2_ff >= DimW'(IdxW)) ? '1 : IdxW'(dim_size - (IdxW+1)'(1));

   // loop counters: i outer, k middle, j inner
   always_comb begin
      i_in = i_ff;
      k_in = k_ff;
      j_in = j_ff;
      if (cmd.mac_start) begin
         i_in = '0;
         k_in = '0;
         j_in = '0;
      end else if (cmd.row_next) begin
         j_in = '0;
         if (k_ff == last_idx) begin
            k_in = '0;
            i_in = i_ff + IdxW'(1);
         end else begin
            k_in = k_ff + IdxW'(1);
         end
      end else if (cmd.issue) begin
         j_in = j_ff + IdxW'(1);
      end
   end

   assign clr_cnt_in = cmd.clear_en ? clr_cnt_ff + AddrW'(1) : clr_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
         p1_vld_ff  <= 1'b0;
         p2_vld_ff  <= 1'b0;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
         p1_vld_ff  <= cmd.issue;
         p2_vld_ff  <= p1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      i_ff       <= i_in;
      k_ff       <= k_in;
      j_ff       <= j_in;
      p1_addr_ff <= z_raddr;
      p2_addr_ff <= p1_addr_ff;
      prod_ff    <= prod_in;
      z_hold_ff  <= z_rd_ff;
      rsp_ff     <= rsp_in;
   end

   assign req_addr = {req_payload.row, req_payload.col};
   assign z_raddr  = cmd.issue ? {i_ff, j_ff} : req_addr;

   always_ff @(posedge clock) begin
      if (cmd.write_x) x_mem[req_addr] <= req_payload.value;
      if (cmd.load_a) x_rd_ff <= x_mem[{i_ff, k_ff}];
   end

   always_ff @(posedge clock) begin
      if (cmd.write_y) y_mem[req_addr] <= req_payload.value;
      y_rd_ff <= y_mem[{k_ff, j_ff}];
   end

   assign prod_in = x_rd_ff * y_rd_ff;

   assign z_we    = cmd.clear_en || p2_vld_ff;
   assign z_waddr = cmd.clear_en ? clr_cnt_ff : p2_addr_ff;
   assign z_wdata = cmd.clear_en ? '0 : z_hold_ff + prod_ff;

   always_ff @(posedge clock) begin
      if (z_we) z_mem[z_waddr] <= z_wdata;
      z_rd_ff <= z_mem[z_raddr];
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.rsp_load_read) begin
         rsp_in.read_value = z_rd_ff;
         rsp_in.is_read    = 1'b1;
      end else if (cmd.rsp_load_zero) begin
         rsp_in = '0;
      end
   end

   assign rsp_payload       = rsp_ff;
   assign status.clear_last = &clr_cnt_ff;
   assign status.j_last     = (j_ff == last_idx);
   assign status.row_last   = (k_ff == last_idx) && (i_ff == last_idx);
   assign status.pipe_busy  = p1_vld_ff || p2_vld_ff;

endmodule

// File: design/matrix_multiply_accumulate.sv
// Results: X or Y write item, valid in the cycle after accept; Z read, valid after
// the READ state. A multiply item loops over n = 2^dim_log2 (max 32), with
// one Y read, one multiply and one Z read-modify-write per element, plus
// an X load and pipeline drain per (i,k) row.
// One item in flight at a time; a new item is taken once the waiting result leaves.
// Reset: synchronous; a pass then zeros every Z entry with req_ready low.
// ----------------------------------------------------------------------------
// matrix_multiply_accumulate
// Integer matrix multiply-accumulate Z = Z + X*Y over an n-by-n corner.
// ----------------------------------------------------------------------------
module matrix_multiply_accumulate
   import mma_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_wr_en,
   input  logic [DimW-1:0] csr_wr_data,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   cmd_type    cmd;
   status_type status;

   mma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_code  (req_payload.req_type),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mma_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

endmodule

// File: design/mma_checker.sv
// ----------------------------------------------------------------------------
// mma_checker
// Port-level checks for the matrix multiply-accumulate block.
// ----------------------------------------------------------------------------
module mma_checker
   import mma_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input req_payload_type req_payload,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_payload
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("item dropped or changed while stalled");

   a_ready_room: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid || rsp_ready)
      else $error("item taken with no room for its result");

   a_zero_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.is_read |-> rsp_payload.read_value == '0)
      else $error("nonzero value on a non-read result");

   a_write_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready &&
      (req_payload.req_type == REQ_WRITE_X || req_payload.req_type == REQ_WRITE_Y)
      |=> rsp_valid && !rsp_payload.is_read)
      else $error("write item result missing");

   a_clear_block: assert property (@(posedge clock)
      $past(reset) |-> !req_ready)
      else $error("item taken during clearing pass");

endmodule

bind matrix_multiply_accumulate mma_checker u_mma_checker (.*);
